// ===== src/sorted_priority_queue_assert.svh =====
// Assertion helpers used by the queue controller.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define SPQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_priority_queue: same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_priority_queue: next-cycle check failed");

`endif

// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

   // Operation codes of a request beat. The fourth code does nothing.
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   // Status codes of a response beat.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Port strobes from the sequencer to the entry memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ===== src/spq_if.sv =====
`timescale 1ns / 1ps

interface spq_req_if #(
   parameter int PRIO_WIDTH = 32,
   parameter int TAG_WIDTH  = 16
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            op;
   logic [PRIO_WIDTH-1:0] in_priority;
   logic [TAG_WIDTH-1:0]  in_tag;

   modport source (output valid, output op, output in_priority, output in_tag, input ready);
   modport sink   (input valid, input op, input in_priority, input in_tag, output ready);
endinterface

interface spq_rsp_if #(
   parameter int PRIO_WIDTH = 32,
   parameter int TAG_WIDTH  = 16,
   parameter int CNT_WIDTH  = 7
);
   logic                  valid;
   logic                  ready;
   logic [PRIO_WIDTH-1:0] out_priority;
   logic [TAG_WIDTH-1:0]  out_tag;
   logic                  head_valid;
   logic [PRIO_WIDTH-1:0] head_priority;
   logic [TAG_WIDTH-1:0]  head_tag;
   logic [CNT_WIDTH-1:0]  count;
   logic [1:0]            status;

   modport source (output valid, output out_priority, output out_tag, output head_valid,
                   output head_priority, output head_tag, output count, output status,
                   input ready);
   modport sink   (input valid, input out_priority, input out_tag, input head_valid,
                   input head_priority, input head_tag, input count, input status,
                   output ready);
endinterface

// ===== src/spq_store.sv =====
`timescale 1ns / 1ps

module spq_store #(
   parameter int DEPTH      = 64,
   parameter int WIDTH      = 48,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  spq_pkg::mem_ctl_type   ctl,
   input  logic [ADDR_WIDTH-1:0]  wr_addr,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic [ADDR_WIDTH-1:0]  rd_addr,
   output logic [WIDTH-1:0]       rd_data
);
   import spq_pkg::*;

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/spq_ctrl.sv =====
`timescale 1ns / 1ps
`include "sorted_priority_queue_assert.svh"

module spq_ctrl #(
   parameter int CAPACITY   = 64,
   parameter int TAG_WIDTH  = 16,
   parameter int PRIO_WIDTH = 32,
   parameter int ADDR_WIDTH = $clog2(CAPACITY),
   parameter int CNT_WIDTH  = $clog2(CAPACITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   spq_req_if.sink                          req_ch,
   spq_rsp_if.source                        rsp_ch,
   output spq_pkg::mem_ctl_type             mem_ctl,
   output logic [ADDR_WIDTH-1:0]            wr_addr,
   output logic [PRIO_WIDTH+TAG_WIDTH-1:0]  wr_data,
   output logic [ADDR_WIDTH-1:0]            rd_addr,
   input  logic [PRIO_WIDTH+TAG_WIDTH-1:0]  rd_data
);
   import spq_pkg::*;

   localparam int EW = PRIO_WIDTH + TAG_WIDTH;
   localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PLACE,
      S_DEQ_WAIT,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic [ADDR_WIDTH-1:0] ptr_ff, ptr_in;
   logic [PRIO_WIDTH-1:0] head_prio_ff, head_prio_in;
   logic [TAG_WIDTH-1:0]  head_tag_ff, head_tag_in;
   logic [PRIO_WIDTH-1:0] new_prio_ff, new_prio_in;
   logic [TAG_WIDTH-1:0]  new_tag_ff, new_tag_in;
   logic [PRIO_WIDTH-1:0] rem_prio_ff, rem_prio_in;
   logic [TAG_WIDTH-1:0]  rem_tag_ff, rem_tag_in;
   logic [1:0]            status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PRIO_WIDTH-1:0] rsp_out_prio_ff, rsp_out_prio_in;
   logic [TAG_WIDTH-1:0]  rsp_out_tag_ff, rsp_out_tag_in;
   logic                  rsp_head_valid_ff, rsp_head_valid_in;
   logic [PRIO_WIDTH-1:0] rsp_head_prio_ff, rsp_head_prio_in;
   logic [TAG_WIDTH-1:0]  rsp_head_tag_ff, rsp_head_tag_in;
   logic [CNT_WIDTH-1:0]  rsp_count_ff, rsp_count_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  slot_free;
   logic [CNT_WIDTH-1:0]  count_m1;
   logic [CNT_WIDTH-1:0]  count_m2;
   logic [PRIO_WIDTH-1:0] rd_prio;
   logic [TAG_WIDTH-1:0]  rd_tag;
   logic                  rd_lower;

   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign count_m1  = count_ff - CNT_WIDTH'(1);
   assign count_m2  = count_ff - CNT_WIDTH'(2);
   assign rd_prio   = rd_data[EW-1:TAG_WIDTH];
   assign rd_tag    = rd_data[TAG_WIDTH-1:0];
   assign rd_lower  = $signed(rd_prio) < $signed(new_prio_ff);

   // An enqueue walks from the lowest-priority end toward slot zero. Each cycle it
   // compares the entry read last cycle, moves it up one slot if it ranks below the
   // new entry, and already reads the next one down. The write slot always sits two
   // above the read slot, so the two ports never meet on one entry.
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      ptr_in            = ptr_ff;
      head_prio_in      = head_prio_ff;
      head_tag_in       = head_tag_ff;
      new_prio_in       = new_prio_ff;
      new_tag_in        = new_tag_ff;
      rem_prio_in       = rem_prio_ff;
      rem_tag_in        = rem_tag_ff;
      status_in         = status_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_out_prio_in   = rsp_out_prio_ff;
      rsp_out_tag_in    = rsp_out_tag_ff;
      rsp_head_valid_in = rsp_head_valid_ff;
      rsp_head_prio_in  = rsp_head_prio_ff;
      rsp_head_tag_in   = rsp_head_tag_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_status_in     = rsp_status_ff;
      mem_ctl           = '0;
      wr_addr           = ptr_ff + ADDR_WIDTH'(1);
      wr_data           = rd_data;
      rd_addr           = ptr_ff - ADDR_WIDTH'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               new_prio_in = req_ch.in_priority;
               new_tag_in  = req_ch.in_tag;
               rem_prio_in = '0;
               rem_tag_in  = '0;
               status_in   = ST_OK;
               state_in    = S_DONE;
               unique case (req_ch.op)
                  OP_ENQUEUE: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = ST_FULL;
                     end else if (count_ff == '0) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = '0;
                        wr_data       = {req_ch.in_priority, req_ch.in_tag};
                        head_prio_in  = req_ch.in_priority;
                        head_tag_in   = req_ch.in_tag;
                        count_in      = CNT_WIDTH'(1);
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = count_m1[ADDR_WIDTH-1:0];
                        ptr_in        = count_m1[ADDR_WIDTH-1:0];
                        state_in      = S_SCAN;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rem_prio_in = head_prio_ff;
                        rem_tag_in  = head_tag_ff;
                        count_in    = count_m1;
                        // The entry below the old head becomes the new head.
                        if (count_ff != CNT_WIDTH'(1)) begin
                           mem_ctl.rd_en = 1'b1;
                           rd_addr       = count_m2[ADDR_WIDTH-1:0];
                           state_in      = S_DEQ_WAIT;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            mem_ctl.wr_en = 1'b1;
            if (rd_lower) begin
               if (ptr_ff == '0) begin
                  state_in = S_PLACE;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  ptr_in        = ptr_ff - ADDR_WIDTH'(1);
               end
            end else begin
               wr_data  = {new_prio_ff, new_tag_ff};
               count_in = count_ff + CNT_WIDTH'(1);
               state_in = S_DONE;
               // Nothing was moved, so the new entry lands on top and is the new head.
               if (ptr_ff == count_m1[ADDR_WIDTH-1:0]) begin
                  head_prio_in = new_prio_ff;
                  head_tag_in  = new_tag_ff;
               end
            end
         end
         S_PLACE: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = '0;
            wr_data       = {new_prio_ff, new_tag_ff};
            count_in      = count_ff + CNT_WIDTH'(1);
            state_in      = S_DONE;
         end
         S_DEQ_WAIT: begin
            head_prio_in = rd_prio;
            head_tag_in  = rd_tag;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_out_prio_in   = rem_prio_ff;
               rsp_out_tag_in    = rem_tag_ff;
               rsp_head_valid_in = (count_ff != '0);
               rsp_head_prio_in  = (count_ff != '0) ? head_prio_ff : '0;
               rsp_head_tag_in   = (count_ff != '0) ? head_tag_ff : '0;
               rsp_count_in      = count_ff;
               rsp_status_in     = status_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff            <= ptr_in;
      head_prio_ff      <= head_prio_in;
      head_tag_ff       <= head_tag_in;
      new_prio_ff       <= new_prio_in;
      new_tag_ff        <= new_tag_in;
      rem_prio_ff       <= rem_prio_in;
      rem_tag_ff        <= rem_tag_in;
      status_ff         <= status_in;
      rsp_out_prio_ff   <= rsp_out_prio_in;
      rsp_out_tag_ff    <= rsp_out_tag_in;
      rsp_head_valid_ff <= rsp_head_valid_in;
      rsp_head_prio_ff  <= rsp_head_prio_in;
      rsp_head_tag_ff   <= rsp_head_tag_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_priority  = rsp_out_prio_ff;
   assign rsp_ch.out_tag       = rsp_out_tag_ff;
   assign rsp_ch.head_valid    = rsp_head_valid_ff;
   assign rsp_ch.head_priority = rsp_head_prio_ff;
   assign rsp_ch.head_tag      = rsp_head_tag_ff;
   assign rsp_ch.count         = rsp_count_ff;
   assign rsp_ch.status        = rsp_status_ff;

   `SPQ_ASSERT_SAME(a_count_range, 1'b1, count_ff <= FULL_COUNT)
   `SPQ_ASSERT_SAME(a_full_status, rsp_valid_ff && (rsp_status_ff == ST_FULL), rsp_count_ff == FULL_COUNT)
   `SPQ_ASSERT_NEXT(a_deq_count, accept && (req_ch.op == OP_DEQUEUE) && (count_ff != '0), count_ff == $past(count_m1))
   `SPQ_ASSERT_SAME(a_port_clash, mem_ctl.wr_en && mem_ctl.rd_en, wr_addr != rd_addr)

endmodule

// ===== src/sorted_priority_queue.sv =====
`timescale 1ns / 1ps

// Sorted priority queue that hands out the lowest priority first; equal priorities
// leave last in, first out. Each request beat (enqueue, dequeue, clear) yields one
// response beat with the removed entry, the new head, the count and a status. All
// entries sit in one single-port-read, single-port-write memory kept in decreasing
// priority order, and every entry an enqueue has to pass is read and moved up one
// slot per cycle through that memory. A dequeue that leaves a head behind also waits
// for the memory read of the new head. A new request is taken only after the previous
// response is in the output register, which holds it until the consumer takes it.
module sorted_priority_queue #(
   parameter int CAPACITY   = 64,
   parameter int TAG_WIDTH  = 16,
   parameter int PRIO_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);
   import spq_pkg::*;

   localparam int ADDR_WIDTH = $clog2(CAPACITY);
   localparam int CNT_WIDTH  = $clog2(CAPACITY + 1);
   localparam int EW         = PRIO_WIDTH + TAG_WIDTH;

   mem_ctl_type           mem_ctl;
   logic [ADDR_WIDTH-1:0] wr_addr;
   logic [ADDR_WIDTH-1:0] rd_addr;
   logic [EW-1:0]         wr_data;
   logic [EW-1:0]         rd_data;

   spq_ctrl #(
      .CAPACITY   (CAPACITY),
      .TAG_WIDTH  (TAG_WIDTH),
      .PRIO_WIDTH (PRIO_WIDTH),
      .ADDR_WIDTH (ADDR_WIDTH),
      .CNT_WIDTH  (CNT_WIDTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spq_store #(
      .DEPTH      (CAPACITY),
      .WIDTH      (EW),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
